FILE: rtl/pces_pkg.sv
// types and constants for the execute stage
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package pces_pkg;

	localparam int unsigned WordW = 32;

	// instruction codes
	localparam logic [3:0] CMD_HALT  = 4'd0;
	localparam logic [3:0] CMD_NOP   = 4'd1;
	localparam logic [3:0] CMD_RRMOV = 4'd2;
	localparam logic [3:0] CMD_IRMOV = 4'd3;
	localparam logic [3:0] CMD_RMMOV = 4'd4;
	localparam logic [3:0] CMD_MRMOV = 4'd5;
	localparam logic [3:0] CMD_OP    = 4'd6;
	localparam logic [3:0] CMD_JUMP  = 4'd7;
	localparam logic [3:0] CMD_CALL  = 4'd8;
	localparam logic [3:0] CMD_RET   = 4'd9;
	localparam logic [3:0] CMD_PUSH  = 4'd10;
	localparam logic [3:0] CMD_POP   = 4'd11;
	localparam logic [3:0] CMD_DUMP  = 4'd12;

	// alu functions
	localparam logic [3:0] FN_ADD = 4'd0;
	localparam logic [3:0] FN_SUB = 4'd1;
	localparam logic [3:0] FN_AND = 4'd2;
	localparam logic [3:0] FN_XOR = 4'd3;

	// condition selectors
	localparam logic [3:0] CC_ALWAYS = 4'd0;
	localparam logic [3:0] CC_LE     = 4'd1;
	localparam logic [3:0] CC_L      = 4'd2;
	localparam logic [3:0] CC_E      = 4'd3;
	localparam logic [3:0] CC_NE     = 4'd4;
	localparam logic [3:0] CC_GE     = 4'd5;
	localparam logic [3:0] CC_G      = 4'd6;

	localparam logic [3:0] REG_NONE = 4'd15;

	localparam logic [1:0] STAT_OK = 2'd0;

	localparam logic [WordW-1:0] STACK_DEC = 32'hFFFF_FFFC;
	localparam logic [WordW-1:0] STACK_INC = 32'h0000_0004;

	typedef struct packed {
		logic zf;
		logic sf;
		logic of;
	} flags_t;

	localparam flags_t FLAGS_RESET = '{zf: 1'b1, sf: 1'b0, of: 1'b0};

endpackage

`default_nettype wire

FILE: rtl/pces_alu.sv
// operand selection, alu and flag computation for one instruction
// depends on pces_pkg
`timescale 1ns / 1ps
`default_nettype none

module pces_alu
	import pces_pkg::*;
(
	input  wire logic [3:0]       cmd,
	input  wire logic [3:0]       func_code,
	input  wire logic [WordW-1:0] const_word,
	input  wire logic [WordW-1:0] reg_a_value,
	input  wire logic [WordW-1:0] reg_b_value,
	output logic      [WordW-1:0] result,
	output flags_t                flags
);

	logic [WordW-1:0] op_a;
	logic [WordW-1:0] op_b;
	logic [3:0]       alu_fn;
	logic             sa, sb, sr;

	always_comb begin
		case (cmd) inside
			CMD_RRMOV, CMD_OP:                        op_a = reg_a_value;
			CMD_IRMOV, CMD_RMMOV, CMD_MRMOV, CMD_DUMP: op_a = const_word;
			CMD_CALL, CMD_PUSH:                       op_a = STACK_DEC;
			CMD_RET, CMD_POP:                         op_a = STACK_INC;
			default:                                  op_a = '0;
		endcase
	end

	always_comb begin
		case (cmd) inside
			CMD_RMMOV, CMD_MRMOV, CMD_OP, CMD_CALL, CMD_RET, CMD_PUSH, CMD_POP:
				op_b = reg_b_value;
			default: op_b = '0;
		endcase
	end

	assign alu_fn = (cmd == CMD_OP) ? func_code : FN_ADD;

	always_comb begin
		unique case (alu_fn)
			FN_ADD:  result = op_a + op_b;
			FN_SUB:  result = op_b - op_a;
			FN_AND:  result = op_a & op_b;
			FN_XOR:  result = op_a ^ op_b;
			default: result = '0;
		endcase
	end

	assign sa = op_a[WordW-1];
	assign sb = op_b[WordW-1];
	assign sr = result[WordW-1];

	always_comb begin
		flags.zf = (result == '0);
		flags.sf = sr;
		case (alu_fn)
			FN_ADD:  flags.of = (sa == sb) && (sr != sa);
			FN_SUB:  flags.of = (sa != sb) && (sr != sb);
			default: flags.of = 1'b0;
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/pces_cond.sv
// jump and conditional-move condition from the current flags
// depends on pces_pkg
`timescale 1ns / 1ps
`default_nettype none

module pces_cond
	import pces_pkg::*;
(
	input  wire logic [3:0] cmd,
	input  wire logic [3:0] func_code,
	input  wire flags_t     flags,
	output logic            cond_true
);

	logic lt;
	logic test;

	assign lt = flags.sf ^ flags.of;

	always_comb begin
		unique case (func_code)
			CC_ALWAYS: test = 1'b1;
			CC_LE:     test = lt | flags.zf;
			CC_L:      test = lt;
			CC_E:      test = flags.zf;
			CC_NE:     test = ~flags.zf;
			CC_GE:     test = ~lt;
			CC_G:      test = ~lt & ~flags.zf;
			default:   test = 1'b0;
		endcase
	end

	// only moves and jumps carry a condition
	assign cond_true = ((cmd == CMD_RRMOV) || (cmd == CMD_JUMP)) && test;

endmodule

`default_nettype wire

FILE: rtl/pipelined_cpu_execute_stage.sv
// execute stage top level: input register, alu and condition logic, result register
// depends on pces_pkg, pces_alu, pces_cond
//
// channel  handshake            direction  payload
// in       in_valid / in_ready  in         cmd .. wb_stage_status (decoded instruction)
// out      out_valid / out_ready out       exec_value .. out_dest_m (executed instruction)
//
// one item per cycle sustained while the output is not stalled; an accepted item passes through
// the input register and then the result register, whose valid bit drives out_valid
// flags update when an unbubbled OP item moves from the input register into the result register
// arst_n clears valid bits and sets flags to zf=1, sf=0, of=0
// a stalled output holds both registers; in_ready stays high while the input register
// is empty or moving on
`timescale 1ns / 1ps
`default_nettype none

module pipelined_cpu_execute_stage
	import pces_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [3:0]       cmd,
	input  wire logic [3:0]       func_code,
	input  wire logic [WordW-1:0] const_word,
	input  wire logic [WordW-1:0] reg_a_value,
	input  wire logic [WordW-1:0] reg_b_value,
	input  wire logic [3:0]       dest_e_reg,
	input  wire logic [3:0]       dest_m_reg,
	input  wire logic [1:0]       in_status,
	input  wire logic [1:0]       mem_stage_status,
	input  wire logic [1:0]       wb_stage_status,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [WordW-1:0] exec_value,
	output logic      [3:0]       exec_dest,
	output logic                  cond_true,
	output logic                  mem_bubble,
	output logic      [1:0]       out_status,
	output logic      [3:0]       out_cmd,
	output logic      [WordW-1:0] out_reg_a_value,
	output logic      [3:0]       out_dest_m
);

	// input register
	logic             valid_s1;
	logic [3:0]       cmd_s1;
	logic [3:0]       fn_s1;
	logic [WordW-1:0] const_s1;
	logic [WordW-1:0] ra_s1;
	logic [WordW-1:0] rb_s1;
	logic [3:0]       de_s1;
	logic [3:0]       dm_s1;
	logic [1:0]       st_s1;
	logic [1:0]       ms_s1;
	logic [1:0]       ws_s1;

	// result register
	logic             valid_s2;
	logic [WordW-1:0] value_s2;
	logic [3:0]       dest_s2;
	logic             cond_s2;
	logic             bubble_s2;
	logic [1:0]       st_s2;
	logic [3:0]       cmd_s2;
	logic [WordW-1:0] ra_s2;
	logic [3:0]       dm_s2;

	flags_t           flags_q;
	flags_t           new_flags;
	logic [WordW-1:0] alu_result;
	logic             cond;
	logic             bubble;
	logic             adv_s1;
	logic             load_s1;
	logic             flag_wr;

	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign load_s1  = in_valid && in_ready;

	assign bubble  = (ms_s1 != STAT_OK) || (ws_s1 != STAT_OK);
	assign flag_wr = adv_s1 && (cmd_s1 == CMD_OP) && !bubble;

	pces_alu u_alu (
		.cmd         (cmd_s1),
		.func_code   (fn_s1),
		.const_word  (const_s1),
		.reg_a_value (ra_s1),
		.reg_b_value (rb_s1),
		.result      (alu_result),
		.flags       (new_flags)
	);

	// a cmd that sets flags never tests them, so the registered flags are current
	pces_cond u_cond (
		.cmd       (cmd_s1),
		.func_code (fn_s1),
		.flags     (flags_q),
		.cond_true (cond)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cmd_s1   <= cmd;
			fn_s1    <= func_code;
			const_s1 <= const_word;
			ra_s1    <= reg_a_value;
			rb_s1    <= reg_b_value;
			de_s1    <= dest_e_reg;
			dm_s1    <= dest_m_reg;
			st_s1    <= in_status;
			ms_s1    <= mem_stage_status;
			ws_s1    <= wb_stage_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			value_s2  <= alu_result;
			dest_s2   <= ((cmd_s1 == CMD_RRMOV) && !cond) ? REG_NONE : de_s1;
			cond_s2   <= cond;
			bubble_s2 <= bubble;
			st_s2     <= st_s1;
			cmd_s2    <= cmd_s1;
			ra_s2     <= ra_s1;
			dm_s2     <= dm_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= FLAGS_RESET;
		end else if (flag_wr) begin
			flags_q <= new_flags;
		end
	end

	assign out_valid       = valid_s2;
	assign exec_value      = value_s2;
	assign exec_dest       = dest_s2;
	assign cond_true       = cond_s2;
	assign mem_bubble      = bubble_s2;
	assign out_status      = st_s2;
	assign out_cmd         = cmd_s2;
	assign out_reg_a_value = ra_s2;
	assign out_dest_m      = dm_s2;

	// flags move only with an OP item leaving the input register unbubbled
	a_flags_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!flag_wr |=> $stable(flags_q))
		else $error("flags changed without an OP item");

	// an untaken conditional move writes no register
	a_cmov_dest: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (cmd_s2 == CMD_RRMOV) && !cond_s2) |-> (dest_s2 == REG_NONE))
		else $error("untaken move kept its destination");

	// only moves and jumps report a true condition
	a_cond_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && cond_s2) |-> ((cmd_s2 == CMD_RRMOV) || (cmd_s2 == CMD_JUMP)))
		else $error("condition true for a non-branch item");

	// an empty input register always takes an item
	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled while input register empty");

	// a stalled result register holds its item and blocks the input register
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |=> (valid_s2 && $stable(value_s2)))
		else $error("result lost under stall");

endmodule

`default_nettype wire

FILE: dv/pipelined_cpu_execute_stage_tb.sv
// self-checking testbench for the execute stage: directed table, then random instructions
// depends on pces_pkg and pipelined_cpu_execute_stage
`timescale 1ns / 1ps

module pipelined_cpu_execute_stage_tb;
	import pces_pkg::*;

	// codes with no name in the package
	localparam logic [3:0] CMD_BAD = 4'd15;
	localparam logic [3:0] FN_BAD  = 4'd15;
	localparam logic [3:0] CC_BAD  = 4'd7;
	localparam logic [1:0] ST_HLT  = 2'd1;
	localparam logic [1:0] ST_ADR  = 2'd2;
	localparam logic [1:0] ST_INS  = 2'd3;

	localparam int PHASE_ITEMS = 460;
	localparam int HOLD_LEN    = 40;
	localparam int STUCK_LIMIT = 2000;
	localparam int TAIL_CYCLES = 10;

	typedef struct packed {
		logic [3:0]       cmd;
		logic [3:0]       fn;
		logic [WordW-1:0] cw;
		logic [WordW-1:0] ra;
		logic [WordW-1:0] rb;
		logic [3:0]       de;
		logic [3:0]       dm;
		logic [1:0]       st;
		logic [1:0]       ms;
		logic [1:0]       ws;
	} instr_t;

	typedef struct packed {
		logic [WordW-1:0] val;
		logic [3:0]       dst;
		logic             cnd;
		logic             bub;
		logic [1:0]       st;
		logic [3:0]       cmd;
		logic [WordW-1:0] ra;
		logic [3:0]       dm;
	} exec_res_t;

	// one table row: instruction, plus a typed-in result when known is set
	typedef struct packed {
		instr_t    ins;
		logic      known;
		exec_res_t res;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	row_t drv = '0;

	logic             in_ready;
	logic             out_valid;
	logic [WordW-1:0] exec_value;
	logic [3:0]       exec_dest;
	logic             cond_true;
	logic             mem_bubble;
	logic [1:0]       out_status;
	logic [3:0]       out_cmd;
	logic [WordW-1:0] out_reg_a_value;
	logic [3:0]       out_dest_m;

	flags_t    cc_flags;
	exec_res_t pending_res[$];
	row_t      dir_tab[$];
	int        errs = 0;
	int        stuck_cnt = 0;
	int        idle_pct = 0;
	int        stall_pct = 0;
	bit        hold_go = 1'b0;
	int        hold_left = 0;

	pipelined_cpu_execute_stage dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.cmd             (drv.ins.cmd),
		.func_code       (drv.ins.fn),
		.const_word      (drv.ins.cw),
		.reg_a_value     (drv.ins.ra),
		.reg_b_value     (drv.ins.rb),
		.dest_e_reg      (drv.ins.de),
		.dest_m_reg      (drv.ins.dm),
		.in_status       (drv.ins.st),
		.mem_stage_status(drv.ins.ms),
		.wb_stage_status (drv.ins.ws),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.exec_value      (exec_value),
		.exec_dest       (exec_dest),
		.cond_true       (cond_true),
		.mem_bubble      (mem_bubble),
		.out_status      (out_status),
		.out_cmd         (out_cmd),
		.out_reg_a_value (out_reg_a_value),
		.out_dest_m      (out_dest_m)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// executes one instruction against the flag copy, updating it as the stage would
	function automatic exec_res_t execute_instr(instr_t ins);
		logic [WordW-1:0] opa;
		logic [WordW-1:0] opb;
		logic [WordW-1:0] sum;
		logic [3:0]       alu_fn;
		logic             lt;
		logic             ovf;
		exec_res_t        r;
		case (ins.cmd)
			CMD_RRMOV, CMD_OP: opa = ins.ra;
			CMD_IRMOV, CMD_RMMOV, CMD_MRMOV, CMD_DUMP: opa = ins.cw;
			CMD_CALL, CMD_PUSH: opa = STACK_DEC;
			CMD_RET, CMD_POP: opa = STACK_INC;
			default: opa = '0;
		endcase
		case (ins.cmd)
			CMD_RMMOV, CMD_MRMOV, CMD_OP, CMD_CALL, CMD_RET, CMD_PUSH, CMD_POP: opb = ins.rb;
			default: opb = '0;
		endcase
		alu_fn = (ins.cmd == CMD_OP) ? ins.fn : FN_ADD;
		case (alu_fn)
			FN_ADD: sum = opa + opb;
			FN_SUB: sum = opb - opa;
			FN_AND: sum = opa & opb;
			FN_XOR: sum = opa ^ opb;
			default: sum = '0;
		endcase
		r.bub = (ins.ms != STAT_OK) || (ins.ws != STAT_OK);
		if (ins.cmd == CMD_OP && !r.bub) begin
			ovf = 1'b0;
			if (alu_fn == FN_ADD)
				ovf = (opa[31] == opb[31]) && (sum[31] != opa[31]);
			else if (alu_fn == FN_SUB)
				ovf = (opa[31] != opb[31]) && (sum[31] != opb[31]);
			cc_flags.zf = (sum == '0);
			cc_flags.sf = sum[31];
			cc_flags.of = ovf;
		end
		// condition sees the flags after this instruction's own update
		lt = cc_flags.sf ^ cc_flags.of;
		r.cnd = 1'b0;
		if (ins.cmd == CMD_RRMOV || ins.cmd == CMD_JUMP) begin
			case (ins.fn)
				CC_ALWAYS: r.cnd = 1'b1;
				CC_LE: r.cnd = lt | cc_flags.zf;
				CC_L: r.cnd = lt;
				CC_E: r.cnd = cc_flags.zf;
				CC_NE: r.cnd = ~cc_flags.zf;
				CC_GE: r.cnd = ~lt;
				CC_G: r.cnd = ~lt & ~cc_flags.zf;
				default: r.cnd = 1'b0;
			endcase
		end
		r.val = sum;
		r.dst = (ins.cmd == CMD_RRMOV && !r.cnd) ? REG_NONE : ins.de;
		r.st  = ins.st;
		r.cmd = ins.cmd;
		r.ra  = ins.ra;
		r.dm  = ins.dm;
		return r;
	endfunction

	function automatic instr_t mk(logic [3:0] c, logic [3:0] f, logic [31:0] w,
			logic [31:0] a, logic [31:0] b, logic [3:0] e, logic [3:0] m,
			logic [1:0] s, logic [1:0] ms, logic [1:0] ws);
		instr_t ins;
		ins = '{cmd: c, fn: f, cw: w, ra: a, rb: b, de: e, dm: m, st: s, ms: ms, ws: ws};
		return ins;
	endfunction

	function automatic exec_res_t rs(logic [31:0] v, logic [3:0] d, logic c, logic bb,
			logic [1:0] s, logic [3:0] op, logic [31:0] a, logic [3:0] m);
		exec_res_t r;
		r = '{val: v, dst: d, cnd: c, bub: bb, st: s, cmd: op, ra: a, dm: m};
		return r;
	endfunction

	task automatic row(input instr_t ins, input logic known, input exec_res_t res);
		dir_tab.push_back('{ins: ins, known: known, res: res});
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h7FFF_FFFF;
			3: return 32'h8000_0000;
			4: return $urandom_range(8);
			default: return $urandom;
		endcase
	endfunction

	function automatic instr_t rand_instr();
		instr_t ins;
		ins.cmd = ($urandom_range(99) < 92) ? 4'($urandom_range(12)) : 4'($urandom_range(15, 13));
		ins.fn  = 4'($urandom_range(15));
		if ($urandom_range(99) < 85) begin
			if (ins.cmd == CMD_OP)
				ins.fn = 4'($urandom_range(3));
			else if (ins.cmd == CMD_JUMP || ins.cmd == CMD_RRMOV)
				ins.fn = 4'($urandom_range(6));
		end
		ins.cw = rand_word();
		ins.ra = rand_word();
		ins.rb = ($urandom_range(99) < 10) ? ins.ra : rand_word();
		ins.de = 4'($urandom_range(15));
		ins.dm = 4'($urandom_range(15));
		ins.st = 2'($urandom_range(3));
		ins.ms = ($urandom_range(99) < 75) ? STAT_OK : 2'($urandom_range(3));
		ins.ws = ($urandom_range(99) < 75) ? STAT_OK : 2'($urandom_range(3));
		return ins;
	endfunction

	task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errs++;
		end
	endtask

	// called at a falling edge, returns at the falling edge after the item is taken
	task automatic send_row(input row_t rw);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		drv <= rw;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_res.size() != 0)
			@(negedge clk);
	endtask

	// receiver side
	initial begin
		forever begin
			@(negedge clk);
			if (hold_go) begin
				hold_go = 1'b0;
				hold_left = HOLD_LEN;
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// handshake monitor, checker and watchdog
	always @(posedge clk) begin
		exec_res_t want;
		bit        moved;
		if (arst_n) begin
			moved = 1'b0;
			if (out_valid && out_ready) begin
				moved = 1'b1;
				if (pending_res.size() == 0) begin
					$error("result item with no instruction outstanding");
					errs++;
				end else begin
					want = pending_res.pop_front();
					cmp_field("exec_value", want.val, exec_value);
					cmp_field("exec_dest", 32'(want.dst), 32'(exec_dest));
					cmp_field("cond_true", 32'(want.cnd), 32'(cond_true));
					cmp_field("mem_bubble", 32'(want.bub), 32'(mem_bubble));
					cmp_field("out_status", 32'(want.st), 32'(out_status));
					cmp_field("out_cmd", 32'(want.cmd), 32'(out_cmd));
					cmp_field("out_reg_a_value", want.ra, out_reg_a_value);
					cmp_field("out_dest_m", 32'(want.dm), 32'(out_dest_m));
				end
			end
			if (in_valid && in_ready) begin
				moved = 1'b1;
				want = execute_instr(drv.ins);
				pending_res.push_back(drv.known ? drv.res : want);
			end
			stuck_cnt = moved ? 0 : stuck_cnt + 1;
			if (stuck_cnt >= STUCK_LIMIT) begin
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	initial begin
		cc_flags = FLAGS_RESET;

		// flags start as zf=1, sf=0, of=0
		row(mk(CMD_JUMP, CC_E, 32'h0000_1234, 32'hAAAA_5555, 32'h1, REG_NONE, REG_NONE,
			STAT_OK, STAT_OK, STAT_OK), 1'b1,
			rs(32'h0, REG_NONE, 1'b1, 1'b0, STAT_OK, CMD_JUMP, 32'hAAAA_5555, REG_NONE));
		row(mk(CMD_RRMOV, CC_NE, 32'h0, 32'hFFFF_FFFF, 32'h1234_5678, 4'd3, 4'd0,
			STAT_OK, STAT_OK, STAT_OK), 1'b1,
			rs(32'hFFFF_FFFF, REG_NONE, 1'b0, 1'b0, STAT_OK, CMD_RRMOV, 32'hFFFF_FFFF, 4'd0));
		row(mk(CMD_OP, FN_ADD, 32'h0, 32'hFFFF_FFFF, 32'h1, 4'd0, REG_NONE,
			STAT_OK, STAT_OK, STAT_OK), 1'b1,
			rs(32'h0, 4'd0, 1'b0, 1'b0, STAT_OK, CMD_OP, 32'hFFFF_FFFF, REG_NONE));
		// signed overflow on add, then the conditions that read it
		row(mk(CMD_OP, FN_ADD, 32'h0, 32'h7FFF_FFFF, 32'h1, 4'd1, 4'd2,
			STAT_OK, STAT_OK, STAT_OK), 1'b0, '0);
		row(mk(CMD_JUMP, CC_L, 32'h0, 32'h0, 32'h0, 4'd1, 4'd1, STAT_OK, STAT_OK, STAT_OK),
			1'b0, '0);
		row(mk(CMD_JUMP, CC_G, 32'h0, 32'h0, 32'h0, 4'd1, 4'd1, STAT_OK, STAT_OK, STAT_OK),
			1'b0, '0);
		row(mk(CMD_RRMOV, CC_ALWAYS, 32'h0, 32'h5555_AAAA, 32'h0, 4'd7, 4'd8,
			STAT_OK, STAT_OK, STAT_OK), 1'b0, '0);
		row(mk(CMD_OP, FN_SUB, 32'h0, 32'h1, 32'h8000_0000, 4'd2, 4'd3,
			STAT_OK, STAT_OK, STAT_OK), 1'b0, '0);
		row(mk(CMD_RRMOV, CC_L, 32'h0, 32'h0000_00FF, 32'h0, 4'd4, 4'd5,
			STAT_OK, STAT_OK, STAT_OK), 1'b0, '0);
		row(mk(CMD_OP, FN_AND, 32'h0, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 4'd5, 4'd6,
			STAT_OK, STAT_OK, STAT_OK), 1'b0, '0);
		row(mk(CMD_OP, FN_XOR, 32'h0, 32'hFFFF_0000, 32'h0000_FFFF, 4'd6, 4'd7,
			STAT_OK, STAT_OK, STAT_OK), 1'b0, '0);
		// unknown alu function gives zero and still sets the flags
		row(mk(CMD_OP, FN_BAD, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd5, 4'd6,
			STAT_OK, STAT_OK, STAT_OK), 1'b1,
			rs(32'h0, 4'd5, 1'b0, 1'b0, STAT_OK, CMD_OP, 32'hFFFF_FFFF, 4'd6));
		// later stage faulting: bubble and flags left alone
		row(mk(CMD_OP, FN_SUB, 32'h0, 32'h0, 32'h8000_0000, 4'd8, 4'd9,
			STAT_OK, ST_HLT, STAT_OK), 1'b0, '0);
		row(mk(CMD_JUMP, CC_E, 32'h0, 32'h0, 32'h0, 4'd9, 4'd10, STAT_OK, ST_ADR, STAT_OK),
			1'b0, '0);
		row(mk(CMD_NOP, CC_ALWAYS, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, REG_NONE, 4'd0,
			ST_INS, STAT_OK, ST_INS), 1'b1,
			rs(32'h0, REG_NONE, 1'b0, 1'b1, ST_INS, CMD_NOP, 32'h0, 4'd0));
		// unknown condition is false
		row(mk(CMD_JUMP, CC_BAD, 32'h0, 32'h1234_5678, 32'h0, 4'd2, 4'd9,
			STAT_OK, STAT_OK, STAT_OK), 1'b1,
			rs(32'h0, 4'd2, 1'b0, 1'b0, STAT_OK, CMD_JUMP, 32'h1234_5678, 4'd9));
		row(mk(CMD_RRMOV, CC_BAD, 32'h0, 32'h1, 32'h0, 4'd4, 4'd3,
			STAT_OK, STAT_OK, STAT_OK), 1'b1,
			rs(32'h1, REG_NONE, 1'b0, 1'b0, STAT_OK, CMD_RRMOV, 32'h1, 4'd3));
		// stack and memory addressing, then dump, halt and an unknown instruction code
		row(mk(CMD_CALL, CC_ALWAYS, 32'h0, 32'h0, 32'h0, 4'd4, REG_NONE,
			STAT_OK, STAT_OK, STAT_OK), 1'b0, '0);
		row(mk(CMD_PUSH, CC_ALWAYS, 32'h0, 32'h0, 32'h0000_1000, 4'd4, REG_NONE,
			STAT_OK, STAT_OK, STAT_OK), 1'b0, '0);
		row(mk(CMD_RET, CC_ALWAYS, 32'h0, 32'h0, 32'hFFFF_FFFC, 4'd4, REG_NONE,
			STAT_OK, STAT_OK, STAT_OK), 1'b0, '0);
		row(mk(CMD_POP, CC_ALWAYS, 32'h0, 32'h0, 32'hFFFF_FFFF, 4'd4, 4'd1,
			STAT_OK, STAT_OK, STAT_OK), 1'b0, '0);
		row(mk(CMD_IRMOV, CC_ALWAYS, 32'hDEAD_BEEF, 32'h0, 32'h0, 4'd6, REG_NONE,
			STAT_OK, STAT_OK, STAT_OK), 1'b0, '0);
		row(mk(CMD_RMMOV, CC_ALWAYS, 32'hFFFF_FFFF, 32'h0BAD_F00D, 32'h1, REG_NONE, REG_NONE,
			STAT_OK, STAT_OK, STAT_OK), 1'b0, '0);
		row(mk(CMD_DUMP, FN_BAD, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, REG_NONE, REG_NONE,
			STAT_OK, STAT_OK, STAT_OK), 1'b0, '0);
		row(mk(CMD_HALT, CC_ALWAYS, 32'h0, 32'h0, 32'h0, REG_NONE, REG_NONE,
			ST_HLT, STAT_OK, STAT_OK), 1'b0, '0);
		row(mk(CMD_BAD, FN_BAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, REG_NONE,
			REG_NONE, ST_INS, ST_INS, ST_INS), 1'b0, '0);

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_tab[i])
			send_row(dir_tab[i]);
		drain();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
					// long receiver hold-off so the stage fills and stalls its input
					hold_go = 1'b1;
				end
				1: begin
					idle_pct = 65;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 65;
				end
				default: begin
					idle_pct = 26;
					stall_pct = 26;
				end
			endcase
			repeat (PHASE_ITEMS)
				send_row('{ins: rand_instr(), known: 1'b0, res: '0});
			// sender pauses until every result of this phase is back
			drain();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (errs == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/pces_pkg.sv
rtl/pces_alu.sv
rtl/pces_cond.sv
rtl/pipelined_cpu_execute_stage.sv
dv/pipelined_cpu_execute_stage_tb.sv
